// File: design/orad_pkg.sv
// ----------------------------------------------------------------------------
// orad_pkg: shared types and constants
// Fixed-point formats, angle constants, arctangent table, register codes and
// pipeline latencies for the oscillating axis rotation displacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package orad_pkg;

  // datapath widths
  localparam int ANG_W = 36;  // angle, Q30, up to about five turns
  localparam int SC_W  = 34;  // CORDIC x/y/z and sin/cos, Q30
  localparam int R_W   = 33;  // point minus origin, Q16.16

  // angle constants
  localparam logic [35:0]              TWO_PI_Q32  = 36'd26986075409;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [SC_W-1:0]   GAIN_Q30    = 34'sd652032874;
  localparam logic signed [SC_W-1:0]   ONE_Q30     = 34'sd1073741824;

  localparam int ATAN_LEN = 24;

  // phase reduction: one restoring step per multiple 2pi * 2^k, k = 28 .. 0
  localparam int RED_STEPS   = 29;
  localparam int RED_PER_STG = 2;
  localparam int RED_STG     = (RED_STEPS + RED_PER_STG - 1) / RED_PER_STG;
  localparam int PHASE_LAT   = RED_STG + 3;
  localparam int DISP_LAT    = 6;

  typedef enum logic [2:0] {
    CFG_AXIS_X,
    CFG_AXIS_Y,
    CFG_AXIS_Z,
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_ORIGIN_Z,
    CFG_AMPLITUDE,
    CFG_OMEGA
  } cfg_reg_t;

  typedef struct packed {
    logic signed [R_W-1:0] z;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] x;
  } rvec_t;

  // arctan(2^-i) in Q30, truncated
  function automatic logic [30:0] atan_q30(input int idx);
    case (idx)
      0:  return 31'd843314856;
      1:  return 31'd497837829;
      2:  return 31'd263043836;
      3:  return 31'd133525158;
      4:  return 31'd67021686;
      5:  return 31'd33543515;
      6:  return 31'd16775850;
      7:  return 31'd8388437;
      8:  return 31'd4194282;
      9:  return 31'd2097149;
      10: return 31'd1048575;
      11: return 31'd524287;
      12: return 31'd262143;
      13: return 31'd131071;
      14: return 31'd65535;
      15: return 31'd32767;
      16: return 31'd16383;
      17: return 31'd8191;
      18: return 31'd4095;
      19: return 31'd2047;
      20: return 31'd1023;
      21: return 31'd511;
      22: return 31'd255;
      23: return 31'd127;
      default: return 31'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/orad_phase.sv
// ----------------------------------------------------------------------------
// orad_phase: oscillator phase
// omega * time, reduced modulo two pi (remainder keeps the sign of the
// product), then quartered toward zero to a Q30 angle. Restoring reduction,
// two steps per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module orad_phase (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [31:0]                omega,
  input  wire logic [31:0]                       sim_time,
  output logic                                   out_valid,
  output logic signed [orad_pkg::ANG_W-1:0]      phase
);

  localparam int STG  = orad_pkg::RED_STG;
  localparam int RP   = orad_pkg::RED_PER_STG;
  localparam int KTOP = orad_pkg::RED_STEPS - 1;

  logic               prod_vld;
  logic signed [63:0] prod;

  // element 0 is the magnitude stage, then the reduction stages
  logic        vld      [STG+1];
  logic        neg      [STG+1];
  logic [62:0] mag      [STG+1];
  logic [62:0] mag_next [STG+1];

  logic [orad_pkg::ANG_W-1:0] quarter;

  always_comb begin
    logic [62:0] m;
    logic [62:0] sub;
    m   = '0;
    sub = '0;
    mag_next[0] = prod[63] ? 63'(-prod) : prod[62:0];
    for (int g = 1; g <= STG; g++) begin
      m = mag[g-1];
      for (int j = 0; j < RP; j++) begin
        if (KTOP - (g-1)*RP - j >= 0) begin
          sub = 63'(orad_pkg::TWO_PI_Q32) << (KTOP - (g-1)*RP - j);
          if (m >= sub) begin
            m = m - sub;
          end
        end
      end
      mag_next[g] = m;
    end
  end

  assign quarter = orad_pkg::ANG_W'(mag[STG] >> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      for (int g = 0; g <= STG; g++) begin
        vld[g] <= 1'b0;
      end
    end else if (en) begin
      prod_vld  <= in_valid;
      vld[0]    <= prod_vld;
      for (int g = 1; g <= STG; g++) begin
        vld[g] <= vld[g-1];
      end
      out_valid <= vld[STG];
    end
    if (en) begin
      prod   <= 64'(omega) * 64'($signed({1'b0, sim_time}));
      neg[0] <= prod[63];
      mag[0] <= mag_next[0];
      for (int g = 1; g <= STG; g++) begin
        neg[g] <= neg[g-1];
        mag[g] <= mag_next[g];
      end
      phase <= neg[STG] ? -$signed(quarter) : $signed(quarter);
    end
  end

endmodule

`default_nettype wire

// File: design/orad_sincos.sv
// ----------------------------------------------------------------------------
// orad_sincos: pipelined sine and cosine
// Wraps the angle into (-pi, pi], folds it into [-pi/2, pi/2] and runs one
// CORDIC rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module orad_sincos #(
  parameter int NSTG = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [orad_pkg::ANG_W-1:0] angle,
  output logic                                   out_valid,
  output logic signed [orad_pkg::SC_W-1:0]       sin_val,
  output logic signed [orad_pkg::SC_W-1:0]       cos_val
);

  localparam int W = orad_pkg::SC_W;

  logic                              w_vld;
  logic signed [orad_pkg::ANG_W-1:0] w_ang;
  logic signed [orad_pkg::ANG_W-1:0] w_next;
  logic signed [orad_pkg::ANG_W-1:0] f_ang;
  logic                              f_neg;

  logic                vld [NSTG+1];
  logic                neg [NSTG+1];
  logic signed [W-1:0] x   [NSTG+1];
  logic signed [W-1:0] y   [NSTG+1];
  logic signed [W-1:0] z   [NSTG+1];
  logic signed [W-1:0] cx  [NSTG];
  logic signed [W-1:0] cy  [NSTG];
  logic signed [W-1:0] cz  [NSTG];

  // truncating remainder by two pi, then into [0, 2pi)
  always_comb begin
    w_next = angle;
    if (angle >= orad_pkg::TWO_PI_Q30) begin
      w_next = angle - orad_pkg::TWO_PI_Q30;
    end else if (angle <= -orad_pkg::TWO_PI_Q30) begin
      w_next = angle + orad_pkg::TWO_PI_Q30;
    end
    if (w_next < 0) begin
      w_next = w_next + orad_pkg::TWO_PI_Q30;
    end
  end

  // into (-pi, pi], then fold; a fold negates both results
  always_comb begin
    f_ang = w_ang;
    f_neg = 1'b0;
    if (f_ang > orad_pkg::PI_Q30) begin
      f_ang = f_ang - orad_pkg::TWO_PI_Q30;
    end
    if (f_ang > orad_pkg::HALF_PI_Q30) begin
      f_ang = f_ang - orad_pkg::PI_Q30;
      f_neg = 1'b1;
    end else if (f_ang < -orad_pkg::HALF_PI_Q30) begin
      f_ang = f_ang + orad_pkg::PI_Q30;
      f_neg = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      if (z[i] >= 0) begin
        cx[i] = x[i] - (y[i] >>> i);
        cy[i] = y[i] + (x[i] >>> i);
        cz[i] = z[i] - $signed(W'(orad_pkg::atan_q30(i)));
      end else begin
        cx[i] = x[i] + (y[i] >>> i);
        cy[i] = y[i] - (x[i] >>> i);
        cz[i] = z[i] + $signed(W'(orad_pkg::atan_q30(i)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      w_vld  <= in_valid;
      vld[0] <= w_vld;
      for (int i = 1; i <= NSTG; i++) begin
        vld[i] <= vld[i-1];
      end
      out_valid <= vld[NSTG];
    end
    if (en) begin
      w_ang  <= w_next;
      x[0]   <= orad_pkg::GAIN_Q30;
      y[0]   <= '0;
      z[0]   <= W'(f_ang);
      neg[0] <= f_neg;
      for (int i = 0; i < NSTG; i++) begin
        x[i+1]   <= cx[i];
        y[i+1]   <= cy[i];
        z[i+1]   <= cz[i];
        neg[i+1] <= neg[i];
      end
      sin_val <= neg[NSTG] ? -y[NSTG] : y[NSTG];
      cos_val <= neg[NSTG] ? -x[NSTG] : x[NSTG];
    end
  end

endmodule

`default_nettype wire

// File: design/orad_disp.sv
// ----------------------------------------------------------------------------
// orad_disp: Rodrigues displacement
// d = r*(cos-1) + (a x r)*sin + (a.r)*(1-cos)*a, each Q30 product floored,
// summed exactly and saturated. Six stages, the last is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module orad_disp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire orad_pkg::rvec_t               rvec,
  input  wire logic signed [orad_pkg::SC_W-1:0] sin_val,
  input  wire logic signed [orad_pkg::SC_W-1:0] cos_val,
  input  wire logic signed [15:0]            axis_x,
  input  wire logic signed [15:0]            axis_y,
  input  wire logic signed [15:0]            axis_z,
  output logic                               out_valid,
  output logic signed [31:0]                 disp_x,
  output logic signed [31:0]                 disp_y,
  output logic signed [31:0]                 disp_z
);

  localparam int W  = orad_pkg::SC_W;
  localparam int RW = orad_pkg::R_W;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic signed [15:0]   a  [3];
  logic signed [RW-1:0] rv [3];
  logic signed [W-1:0]  cm1;
  logic signed [W-1:0]  omc;

  // stage 0
  logic                vld0;
  logic signed [48:0]  pc [3];
  logic signed [48:0]  pm [3];
  logic signed [48:0]  pd [3];
  logic signed [51:0]  rh [3];
  logic signed [51:0]  rl [3];
  logic signed [W-1:0] s0, c0;
  // stage 1
  logic                vld1;
  logic signed [34:0]  cr [3];
  logic signed [35:0]  dot;
  logic signed [35:0]  t1a [3];
  logic signed [W-1:0] s1, c1;
  // stage 2
  logic                vld2;
  logic signed [53:0]  ch [3];
  logic signed [53:0]  cl [3];
  logic signed [54:0]  dh, dl;
  logic signed [35:0]  t1b [3];
  // stage 3
  logic                vld3;
  logic signed [35:0]  t2a [3];
  logic signed [37:0]  dotm;
  logic signed [35:0]  t1c [3];
  // stage 4
  logic                vld4;
  logic signed [39:0]  t3 [3];
  logic signed [35:0]  t2b [3];
  logic signed [35:0]  t1d [3];

  logic signed [41:0]  sum [3];
  logic signed [31:0]  sat [3];

  assign a[0]  = axis_x;
  assign a[1]  = axis_y;
  assign a[2]  = axis_z;
  assign rv[0] = rvec.x;
  assign rv[1] = rvec.y;
  assign rv[2] = rvec.z;
  assign cm1   = cos_val - orad_pkg::ONE_Q30;
  assign omc   = orad_pkg::ONE_Q30 - c1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 42'(t1d[k]) + 42'(t2b[k]) + 42'(t3[k]);
      if (sum[k] > 42'sd2147483647) begin
        sat[k] = 32'sh7fffffff;
      end else if (sum[k] < -42'sd2147483648) begin
        sat[k] = 32'sh80000000;
      end else begin
        sat[k] = 32'(sum[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0      <= 1'b0;
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      vld4      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld0      <= in_valid;
      vld1      <= vld0;
      vld2      <= vld1;
      vld3      <= vld2;
      vld4      <= vld3;
      out_valid <= vld4;
    end
    if (en) begin
      // products of axis and offset; r*(cos-1) split at bit 15
      for (int k = 0; k < 3; k++) begin
        pc[k] <= 49'(a[NXT[k]]) * 49'(rv[PRV[k]]);
        pm[k] <= 49'(a[PRV[k]]) * 49'(rv[NXT[k]]);
        pd[k] <= 49'(a[k]) * 49'(rv[k]);
        rh[k] <= 52'(rv[k] >>> 15) * 52'(cm1);
        rl[k] <= 52'($signed({1'b0, rv[k][14:0]})) * 52'(cm1);
      end
      s0 <= sin_val;
      c0 <= cos_val;

      for (int k = 0; k < 3; k++) begin
        cr[k]  <= 35'((50'(pc[k]) - 50'(pm[k])) >>> 15);
        t1a[k] <= 36'(((68'(rh[k]) <<< 15) + 68'(rl[k])) >>> 30);
      end
      dot <= 36'((51'(pd[0]) + 51'(pd[1]) + 51'(pd[2])) >>> 15);
      s1  <= s0;
      c1  <= c0;

      for (int k = 0; k < 3; k++) begin
        ch[k]  <= 54'(cr[k] >>> 15) * 54'(s1);
        cl[k]  <= 54'($signed({1'b0, cr[k][14:0]})) * 54'(s1);
        t1b[k] <= t1a[k];
      end
      dh <= 55'(dot >>> 15) * 55'(omc);
      dl <= 55'($signed({1'b0, dot[14:0]})) * 55'(omc);

      for (int k = 0; k < 3; k++) begin
        t2a[k] <= 36'(((70'(ch[k]) <<< 15) + 70'(cl[k])) >>> 30);
        t1c[k] <= t1b[k];
      end
      dotm <= 38'(((70'(dh) <<< 15) + 70'(dl)) >>> 30);

      for (int k = 0; k < 3; k++) begin
        t3[k]  <= 40'((54'(dotm) * 54'(a[k])) >>> 15);
        t2b[k] <= t2a[k];
        t1d[k] <= t1c[k];
      end

      disp_x <= sat[0];
      disp_y <= sat[1];
      disp_z <= sat[2];
    end
  end

endmodule

`default_nettype wire

// File: design/oscillating_axis_rotation_displacement.sv
// ----------------------------------------------------------------------------
// oscillating_axis_rotation_displacement: angular oscillation displacement
// Rotates each rest point about a fixed axis by an oscillating angle and
// returns the displacement from the rest point.
// ----------------------------------------------------------------------------
// Input stream s_axis: one item per point (time and rest point), output
// stream m_axis: one displacement item per input item, in order.
// Configuration: write cfg_index / cfg_data with cfg_valid; cfg_ready is
// always high. Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. From accept
// to m_axis_tvalid an item passes the phase reduction, the two chained CORDIC
// rotators (N = CORDIC_STAGES rotations each, capped at 24) and the Rodrigues
// multiply stages.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls a valid result, s_axis_tready is low and nothing
// in the pipeline moves, so no item is lost or repeated.
// Reset clears all valid bits and loads the register reset values
// (axis 0,0,32767, the rest zero).
// ----------------------------------------------------------------------------
`default_nettype none

module oscillating_axis_rotation_displacement #(
  parameter int BASE_ANGLE    = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // sim_time [31:0], rest_x [63:32], rest_y [95:64], rest_z [127:96]
  input  wire logic [127:0]  s_axis_tdata,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // disp_x [31:0], disp_y [63:32], disp_z [95:64]
  output logic [95:0]        m_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  localparam int ANG_W = orad_pkg::ANG_W;
  localparam int SC_W  = orad_pkg::SC_W;
  localparam int RW    = orad_pkg::R_W;
  localparam int NSTG  = (CORDIC_STAGES > orad_pkg::ATAN_LEN) ?
                         orad_pkg::ATAN_LEN : CORDIC_STAGES;
  localparam int DLY   = orad_pkg::PHASE_LAT + 2 * (NSTG + 3) + 2;
  localparam logic signed [ANG_W-1:0] BASE_Q30 =
    ANG_W'(longint'(BASE_ANGLE) * 64'sd131072);

  logic signed [15:0] axis_x, axis_y, axis_z, amplitude;
  logic signed [31:0] origin_x, origin_y, origin_z, omega;

  logic en;

  logic                    ph_vld;
  logic signed [ANG_W-1:0] phase;
  logic                    sp_vld;
  logic signed [SC_W-1:0]  sp, cp;
  logic                    tp_vld;
  logic signed [49:0]      tp;
  logic                    th_vld;
  logic signed [ANG_W-1:0] theta;
  logic                    sc_vld;
  logic signed [SC_W-1:0]  s_th, c_th;

  orad_pkg::rvec_t r_in;
  orad_pkg::rvec_t dl_r   [DLY];
  logic            dl_vld [DLY];

  logic signed [31:0] disp_x, disp_y, disp_z;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {disp_z, disp_y, disp_x};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x    <= '0;
      axis_y    <= '0;
      axis_z    <= 16'sd32767;
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      amplitude <= '0;
      omega     <= '0;
    end else if (cfg_valid) begin
      case (orad_pkg::cfg_reg_t'(cfg_index))
        orad_pkg::CFG_AXIS_X:    axis_x    <= cfg_data[15:0];
        orad_pkg::CFG_AXIS_Y:    axis_y    <= cfg_data[15:0];
        orad_pkg::CFG_AXIS_Z:    axis_z    <= cfg_data[15:0];
        orad_pkg::CFG_ORIGIN_X:  origin_x  <= cfg_data;
        orad_pkg::CFG_ORIGIN_Y:  origin_y  <= cfg_data;
        orad_pkg::CFG_ORIGIN_Z:  origin_z  <= cfg_data;
        orad_pkg::CFG_AMPLITUDE: amplitude <= cfg_data[15:0];
        orad_pkg::CFG_OMEGA:     omega     <= cfg_data;
        default: ;
      endcase
    end
  end

  orad_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .omega     (omega),
    .sim_time  (s_axis_tdata[31:0]),
    .out_valid (ph_vld),
    .phase     (phase)
  );

  orad_sincos #(.NSTG(NSTG)) u_sc_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ph_vld),
    .angle     (phase),
    .out_valid (sp_vld),
    .sin_val   (sp),
    .cos_val   (cp)
  );

  // theta = base + floor(amplitude * sin(phase) / 2^13); cosine of the
  // phase is not needed
  always_ff @(posedge clk) begin
    if (rst) begin
      tp_vld <= 1'b0;
      th_vld <= 1'b0;
    end else if (en) begin
      tp_vld <= sp_vld;
      th_vld <= tp_vld;
    end
    if (en) begin
      tp    <= 50'(amplitude) * 50'(sp);
      theta <= BASE_Q30 + ANG_W'(tp >>> 13);
    end
  end

  orad_sincos #(.NSTG(NSTG)) u_sc_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (th_vld),
    .angle     (theta),
    .out_valid (sc_vld),
    .sin_val   (s_th),
    .cos_val   (c_th)
  );

  // offset from origin rides alongside the angle pipeline
  assign r_in.x = RW'($signed(s_axis_tdata[63:32]))  - RW'(origin_x);
  assign r_in.y = RW'($signed(s_axis_tdata[95:64]))  - RW'(origin_y);
  assign r_in.z = RW'($signed(s_axis_tdata[127:96])) - RW'(origin_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        dl_vld[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld[0] <= s_axis_tvalid;
      for (int i = 1; i < DLY; i++) begin
        dl_vld[i] <= dl_vld[i-1];
      end
    end
    if (en) begin
      dl_r[0] <= r_in;
      for (int i = 1; i < DLY; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  orad_disp u_disp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sc_vld),
    .rvec      (dl_r[DLY-1]),
    .sin_val   (s_th),
    .cos_val   (c_th),
    .axis_x    (axis_x),
    .axis_y    (axis_y),
    .axis_z    (axis_z),
    .out_valid (m_axis_tvalid),
    .disp_x    (disp_x),
    .disp_y    (disp_y),
    .disp_z    (disp_z)
  );

  // the offset line must stay in step with the angle pipeline
  a_align: assert property (@(posedge clk) disable iff (rst)
    sc_vld == dl_vld[DLY-1])
    else $error("offset delay line out of step with rotator");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("item accepted while output stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
